/* hdl/nssd_pkg.sv */
// Shared types and constants for the NMEA-style sentence decoder.
package nssd_pkg;

  localparam int MAX_PAYLOAD = 64;
  localparam int COUNT_W     = $clog2(MAX_PAYLOAD + 1);

  localparam logic [7:0] CHAR_DOLLAR  = 8'h24;
  localparam logic [7:0] CHAR_STAR    = 8'h2A;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_COMMA   = 8'h2C;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;

  localparam logic [2:0] ST_WAIT = 3'd0;
  localparam logic [2:0] ST_GOOD = 3'd1;
  localparam logic [2:0] ST_FAIL = 3'd2;
  localparam logic [2:0] ST_COO  = 3'd3;
  localparam logic [2:0] ST_HIT  = 3'd4;
  localparam logic [2:0] ST_CHA  = 3'd5;
  localparam logic [2:0] ST_DET  = 3'd6;

  typedef struct packed {
    logic [2:0]  parse_status;
    logic [7:0]  row_value;
    logic [7:0]  col_value;
    logic [7:0]  hit_value;
    logic [15:0] first_word;
    logic [15:0] second_word;
  } result_t;

endpackage

/* hdl/nssd_parser.sv */
// Per-byte sentence parser: sentence state and the result of the current byte.
module nssd_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  logic [7:0]       rx_byte,
  output nssd_pkg::result_t res
);
  import nssd_pkg::*;

  typedef enum logic [2:0] {
    PH_WAIT, PH_REC, PH_HEX1, PH_HEX2, PH_NL
  } phase_t;

  typedef enum logic [2:0] {
    K_NONE, K_HIT, K_COO, K_CHA, K_DET, K_CPEND
  } kind_t;

  phase_t             phase, phase_next;
  logic [COUNT_W-1:0] payload_count, payload_count_next;
  logic [7:0]         running_xor, running_xor_next;
  logic [3:0]         high_nibble, high_nibble_next;
  kind_t              message_kind, message_kind_next;
  logic [1:0]         field_number, field_number_next;
  logic [15:0]        acc [3];
  logic [15:0]        acc_next [3];
  logic               format_bad, format_bad_next;
  logic               digit_seen, digit_seen_next;

  logic [4:0]  hex;
  logic        is_digit;
  logic [1:0]  idx;
  logic [15:0] acc_sel;
  logic [15:0] acc_mul;
  logic        narrow;
  logic [1:0]  needed;
  logic        nl_ok;

  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c inside {[8'h30:8'h39]}) begin
      v = {1'b0, 4'(c - 8'h30)};
    end else if (c inside {[8'h41:8'h46]}) begin
      v = {1'b0, 4'(c - 8'h37)};
    end else if (c inside {[8'h61:8'h66]}) begin
      v = {1'b0, 4'(c - 8'h57)};
    end
    return v;
  endfunction

  always_comb begin
    hex      = hex_value(rx_byte);
    is_digit = rx_byte inside {[8'h30:8'h39]};
    idx      = (field_number == 2'd3) ? 2'd2 : field_number;
    acc_sel  = acc[idx];
    acc_mul  = (acc_sel << 3) + (acc_sel << 1) + {8'h00, rx_byte - CHAR_ZERO};
    narrow   = (message_kind == K_HIT) || (message_kind == K_COO);
    needed   = (message_kind == K_HIT) ? 2'd3 : 2'd2;
    nl_ok    = (rx_byte == CHAR_NEWLINE) && !format_bad && digit_seen &&
               ((message_kind == K_HIT) || (message_kind == K_COO) ||
                (message_kind == K_CHA) || (message_kind == K_DET)) &&
               (payload_count >= COUNT_W'(5)) &&
               ({1'b0, field_number} + 3'd1 == {1'b0, needed});
  end

  always_comb begin
    phase_next         = phase;
    payload_count_next = payload_count;
    running_xor_next   = running_xor;
    high_nibble_next   = high_nibble;
    message_kind_next  = message_kind;
    field_number_next  = field_number;
    acc_next           = acc;
    format_bad_next    = format_bad;
    digit_seen_next    = digit_seen;
    res                = '0;
    res.parse_status   = ST_FAIL;
    case (phase)
      PH_WAIT: begin
        if (rx_byte == CHAR_DOLLAR) begin
          payload_count_next = '0;
          running_xor_next   = '0;
          high_nibble_next   = '0;
          message_kind_next  = K_NONE;
          field_number_next  = '0;
          acc_next[0]        = '0;
          acc_next[1]        = '0;
          acc_next[2]        = '0;
          format_bad_next    = 1'b0;
          digit_seen_next    = 1'b0;
          phase_next         = PH_REC;
          res.parse_status   = ST_GOOD;
        end else begin
          res.parse_status = ST_WAIT;
        end
      end
      PH_REC: begin
        if (rx_byte == CHAR_STAR) begin
          phase_next       = PH_HEX1;
          res.parse_status = ST_GOOD;
        end else if (payload_count >= COUNT_W'(MAX_PAYLOAD)) begin
          phase_next = PH_WAIT;
        end else begin
          running_xor_next   = running_xor ^ rx_byte;
          payload_count_next = payload_count + COUNT_W'(1);
          res.parse_status   = ST_GOOD;
          if (payload_count == COUNT_W'(0)) begin
            case (rx_byte)
              "H":     message_kind_next = K_HIT;
              "C":     message_kind_next = K_CPEND;
              "D":     message_kind_next = K_DET;
              default: message_kind_next = K_NONE;
            endcase
          end else if (payload_count == COUNT_W'(1)) begin
            if (message_kind == K_HIT && rx_byte == "I") begin
              message_kind_next = K_HIT;
            end else if (message_kind == K_CPEND && rx_byte == "O") begin
              message_kind_next = K_COO;
            end else if (message_kind == K_CPEND && rx_byte == "H") begin
              message_kind_next = K_CHA;
            end else if (message_kind == K_DET && rx_byte == "E") begin
              message_kind_next = K_DET;
            end else begin
              message_kind_next = K_NONE;
            end
          end else if (payload_count == COUNT_W'(2)) begin
            if (!((message_kind == K_HIT && rx_byte == "T") ||
                  (message_kind == K_COO && rx_byte == "O") ||
                  (message_kind == K_CHA && rx_byte == "A") ||
                  (message_kind == K_DET && rx_byte == "T"))) begin
              message_kind_next = K_NONE;
            end
          end else if (payload_count == COUNT_W'(3)) begin
            if (rx_byte != CHAR_COMMA) begin
              format_bad_next = 1'b1;
            end
            field_number_next = '0;
            digit_seen_next   = 1'b0;
          end else if (is_digit) begin
            acc_next[idx]   = narrow ? {8'h00, acc_mul[7:0]} : acc_mul;
            digit_seen_next = 1'b1;
          end else if (rx_byte == CHAR_COMMA) begin
            if (!digit_seen || ({1'b0, field_number} + 3'd1 >= {1'b0, needed})) begin
              format_bad_next = 1'b1;
            end else begin
              field_number_next = field_number + 2'd1;
              digit_seen_next   = 1'b0;
            end
          end else begin
            format_bad_next = 1'b1;
          end
        end
      end
      PH_HEX1: begin
        if (hex[4]) begin
          phase_next = PH_WAIT;
        end else begin
          high_nibble_next = hex[3:0];
          phase_next       = PH_HEX2;
          res.parse_status = ST_GOOD;
        end
      end
      PH_HEX2: begin
        if (hex[4] || ({high_nibble, hex[3:0]} != running_xor)) begin
          phase_next = PH_WAIT;
        end else begin
          phase_next       = PH_NL;
          res.parse_status = ST_GOOD;
        end
      end
      PH_NL: begin
        phase_next = PH_WAIT;
        if (nl_ok) begin
          if (narrow) begin
            res.row_value = acc[0][7:0];
            res.col_value = acc[1][7:0];
            if (message_kind == K_HIT) begin
              res.hit_value    = acc[2][7:0];
              res.parse_status = ST_HIT;
            end else begin
              res.parse_status = ST_COO;
            end
          end else begin
            res.first_word   = acc[0];
            res.second_word  = acc[1];
            res.parse_status = (message_kind == K_CHA) ? ST_CHA : ST_DET;
          end
        end
      end
      default: begin
        phase_next = PH_WAIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_WAIT;
      payload_count <= '0;
      running_xor   <= '0;
      high_nibble   <= '0;
      message_kind  <= K_NONE;
      field_number  <= '0;
      acc[0]        <= '0;
      acc[1]        <= '0;
      acc[2]        <= '0;
      format_bad    <= 1'b0;
      digit_seen    <= 1'b0;
    end else if (take) begin
      phase         <= phase_next;
      payload_count <= payload_count_next;
      running_xor   <= running_xor_next;
      high_nibble   <= high_nibble_next;
      message_kind  <= message_kind_next;
      field_number  <= field_number_next;
      acc           <= acc_next;
      format_bad    <= format_bad_next;
      digit_seen    <= digit_seen_next;
    end
  end

endmodule

/* hdl/nssd_out_reg.sv */
// Result holding register with valid flag for the sentence decoder.
module nssd_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  nssd_pkg::result_t res_in,
  input  logic              ready,
  output logic              valid,
  output nssd_pkg::result_t res_out
);
  import nssd_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule

/* hdl/nmea_style_sentence_decoder.sv */
// Top level of the byte-serial NMEA-style sentence decoder.
// Each accepted byte yields its status in the result register in the cycle after it is accepted.
// Throughput is one byte per cycle; the only stall is a result not yet taken.
// A new byte is accepted in the same cycle that the held result is taken.
// Synchronous reset returns the parser to waiting for a dollar and empties the result.
module nmea_style_sentence_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        rx_valid,
  output logic        rx_ready,
  input  logic [7:0]  rx_byte,
  output logic        res_valid,
  input  logic        res_ready,
  output logic [2:0]  parse_status,
  output logic [7:0]  row_value,
  output logic [7:0]  col_value,
  output logic [7:0]  hit_value,
  output logic [15:0] first_word,
  output logic [15:0] second_word
);
  import nssd_pkg::*;

  logic    take;
  result_t res_comb;
  result_t res_held;

  assign rx_ready = !res_valid || res_ready;
  assign take     = rx_valid && rx_ready;

  nssd_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .rx_byte (rx_byte),
    .res     (res_comb)
  );

  nssd_out_reg u_out_reg (
    .clk     (clk),
    .rst     (rst),
    .load    (take),
    .res_in  (res_comb),
    .ready   (res_ready),
    .valid   (res_valid),
    .res_out (res_held)
  );

  assign parse_status = res_held.parse_status;
  assign row_value    = res_held.row_value;
  assign col_value    = res_held.col_value;
  assign hit_value    = res_held.hit_value;
  assign first_word   = res_held.first_word;
  assign second_word  = res_held.second_word;

`ifndef SYNTHESIS
  a_take_gives_result: assert property (@(posedge clk) disable iff (rst)
    take |=> res_valid)
    else $error("accepted byte produced no result");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |-> !rx_ready)
    else $error("input accepted while result stalled");

  a_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (parse_status == ST_WAIT || parse_status == ST_GOOD ||
                   parse_status == ST_FAIL)) |->
    (row_value == 8'd0 && col_value == 8'd0 && hit_value == 8'd0 &&
     first_word == 16'd0 && second_word == 16'd0))
    else $error("fields nonzero on a non-parsed status");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (parse_status != 3'd7))
    else $error("status code out of range");
`endif

endmodule

/* verif/tb_nmea_style_sentence_decoder.sv */
// Self-checking testbench for the NMEA-style sentence decoder against a byte-level predictor.
module tb_nmea_style_sentence_decoder;
  import nssd_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE, PH_BODY, PH_HEX_HI, PH_HEX_LO, PH_TAIL
  } sentence_phase_t;

  typedef enum logic [2:0] {
    KIND_NONE, KIND_HIT, KIND_COO, KIND_CHA, KIND_DET, KIND_C_PART
  } sentence_kind_t;

  localparam int QUIET_LIMIT = 2000;
  localparam int ITEM_TARGET = 1750;

  class sentence_scoreboard;
    sentence_phase_t phase;
    sentence_kind_t  kind;
    int unsigned     body_len;
    logic [7:0]      xor_sum;
    logic [3:0]      upper_nibble;
    int unsigned     field_idx;
    logic [15:0]     acc [3];
    bit              shape_bad;
    bit              have_digit;
    result_t         expected_q [$];
    int              errors;

    function new();
      phase  = PH_IDLE;
      errors = 0;
      clear();
    endfunction

    function void clear();
      body_len     = 0;
      xor_sum      = '0;
      upper_nibble = '0;
      kind         = KIND_NONE;
      field_idx    = 0;
      acc[0]       = '0;
      acc[1]       = '0;
      acc[2]       = '0;
      shape_bad    = 1'b0;
      have_digit   = 1'b0;
    endfunction

    function int hex_digit(logic [7:0] c);
      if (c >= "0" && c <= "9") return c - "0";
      if (c >= "A" && c <= "F") return c - "A" + 10;
      if (c >= "a" && c <= "f") return c - "a" + 10;
      return 16;
    endfunction

    function int unsigned field_count();
      return (kind == KIND_HIT) ? 3 : 2;
    endfunction

    function void take_payload_char(logic [7:0] c, int unsigned pos);
      int unsigned slot;
      int unsigned sum32;
      if (pos == 0) begin
        if (c == "H") kind = KIND_HIT;
        else if (c == "C") kind = KIND_C_PART;
        else if (c == "D") kind = KIND_DET;
        else kind = KIND_NONE;
      end else if (pos == 1) begin
        if (kind == KIND_HIT && c == "I") kind = KIND_HIT;
        else if (kind == KIND_C_PART && c == "O") kind = KIND_COO;
        else if (kind == KIND_C_PART && c == "H") kind = KIND_CHA;
        else if (kind == KIND_DET && c == "E") kind = KIND_DET;
        else kind = KIND_NONE;
      end else if (pos == 2) begin
        if (!((kind == KIND_HIT && c == "T") || (kind == KIND_COO && c == "O") ||
              (kind == KIND_CHA && c == "A") || (kind == KIND_DET && c == "T")))
          kind = KIND_NONE;
      end else if (pos == 3) begin
        if (c != CHAR_COMMA) shape_bad = 1'b1;
        field_idx  = 0;
        have_digit = 1'b0;
      end else if (c >= "0" && c <= "9") begin
        slot  = (field_idx > 2) ? 2 : field_idx;
        sum32 = acc[slot] * 10 + (c - CHAR_ZERO);
        if (kind == KIND_HIT || kind == KIND_COO) sum32 &= 32'hFF;
        else sum32 &= 32'hFFFF;
        acc[slot]  = sum32[15:0];
        have_digit = 1'b1;
      end else if (c == CHAR_COMMA) begin
        if (!have_digit || field_idx + 1 >= field_count()) begin
          shape_bad = 1'b1;
        end else begin
          field_idx++;
          have_digit = 1'b0;
        end
      end else begin
        shape_bad = 1'b1;
      end
    endfunction

    function void note_byte(logic [7:0] c);
      result_t r;
      int      h;
      bit      ok;
      r = '0;
      r.parse_status = ST_FAIL;
      case (phase)
        PH_IDLE: begin
          if (c == CHAR_DOLLAR) begin
            clear();
            phase = PH_BODY;
            r.parse_status = ST_GOOD;
          end else begin
            r.parse_status = ST_WAIT;
          end
        end
        PH_BODY: begin
          if (c == CHAR_STAR) begin
            phase = PH_HEX_HI;
            r.parse_status = ST_GOOD;
          end else if (body_len >= MAX_PAYLOAD) begin
            phase = PH_IDLE;
          end else begin
            take_payload_char(c, body_len);
            xor_sum ^= c;
            body_len++;
            r.parse_status = ST_GOOD;
          end
        end
        PH_HEX_HI: begin
          h = hex_digit(c);
          if (h > 15) begin
            phase = PH_IDLE;
          end else begin
            upper_nibble = h[3:0];
            phase = PH_HEX_LO;
            r.parse_status = ST_GOOD;
          end
        end
        PH_HEX_LO: begin
          h = hex_digit(c);
          if (h > 15 || {upper_nibble, h[3:0]} != xor_sum) begin
            phase = PH_IDLE;
          end else begin
            phase = PH_TAIL;
            r.parse_status = ST_GOOD;
          end
        end
        PH_TAIL: begin
          ok = (c == CHAR_NEWLINE) && !shape_bad && have_digit &&
               (kind == KIND_HIT || kind == KIND_COO || kind == KIND_CHA ||
                kind == KIND_DET) &&
               body_len >= 5 && field_idx + 1 == field_count();
          phase = PH_IDLE;
          if (ok) begin
            if (kind == KIND_HIT || kind == KIND_COO) begin
              r.row_value = acc[0][7:0];
              r.col_value = acc[1][7:0];
              if (kind == KIND_HIT) begin
                r.hit_value = acc[2][7:0];
                r.parse_status = ST_HIT;
              end else begin
                r.parse_status = ST_COO;
              end
            end else begin
              r.first_word  = acc[0];
              r.second_word = acc[1];
              r.parse_status = (kind == KIND_CHA) ? ST_CHA : ST_DET;
            end
          end
        end
        default: phase = PH_IDLE;
      endcase
      expected_q.push_back(r);
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task compare_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want) report($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    task check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("status %0d arrived with nothing pending", got.parse_status));
        return;
      end
      want = expected_q.pop_front();
      compare_field("parse_status", 16'(got.parse_status), 16'(want.parse_status));
      compare_field("row_value", 16'(got.row_value), 16'(want.row_value));
      compare_field("col_value", 16'(got.col_value), 16'(want.col_value));
      compare_field("hit_value", 16'(got.hit_value), 16'(want.hit_value));
      compare_field("first_word", got.first_word, want.first_word);
      compare_field("second_word", got.second_word, want.second_word);
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        rx_valid;
  logic        rx_ready;
  logic [7:0]  rx_byte;
  logic        res_valid;
  logic        res_ready;
  logic [2:0]  parse_status;
  logic [7:0]  row_value;
  logic [7:0]  col_value;
  logic [7:0]  hit_value;
  logic [15:0] first_word;
  logic [15:0] second_word;

  sentence_scoreboard sb;
  logic [7:0]  body [$];
  logic [7:0]  frame [$];
  int unsigned bytes_sent;
  int          send_gap_max;
  int          take_gap_max;

  nmea_style_sentence_decoder i_dut (
    .clk          (clk),
    .rst          (rst),
    .rx_valid     (rx_valid),
    .rx_ready     (rx_ready),
    .rx_byte      (rx_byte),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .parse_status (parse_status),
    .row_value    (row_value),
    .col_value    (col_value),
    .hit_value    (hit_value),
    .first_word   (first_word),
    .second_word  (second_word)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic logic [7:0] to_hex(logic [3:0] n, bit lower);
    if (n < 10) return CHAR_ZERO + n;
    return 8'((lower ? "a" : "A") + n - 10);
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) body.push_back(s[i]);
  endfunction

  function automatic logic [7:0] body_xor();
    logic [7:0] sum;
    sum = '0;
    foreach (body[i]) sum ^= body[i];
    return sum;
  endfunction

  function automatic void seal_body(logic [7:0] sum, bit lower);
    frame.push_back(CHAR_DOLLAR);
    foreach (body[i]) frame.push_back(body[i]);
    frame.push_back(CHAR_STAR);
    frame.push_back(to_hex(sum[7:4], lower));
    frame.push_back(to_hex(sum[3:0], lower));
  endfunction

  task automatic send_byte(logic [7:0] b);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    @(negedge clk);
    if (gap > 0) begin
      rx_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (rx_ready !== 1'b1);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  task automatic send_frame();
    foreach (frame[i]) send_byte(frame[i]);
    frame.delete();
  endtask

  task automatic drain();
    @(negedge clk);
    rx_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic random_sentence();
    int         kind;
    int         mode;
    int         tail_mode;
    int         ndig;
    int         target;
    bit         wide;
    bit         lower;
    logic [7:0] sum;
    logic [7:0] last;
    body.delete();
    kind = $urandom_range(0, 3);
    case (kind)
      0: put_text("HIT");
      1: put_text("COO");
      2: put_text("CHA");
      default: put_text("DET");
    endcase
    wide = (kind >= 2);
    for (int f = 0; f < ((kind == 0) ? 3 : 2); f++) begin
      body.push_back(CHAR_COMMA);
      if ($urandom_range(0, 7) == 0) begin
        if (wide) put_text("65535");
        else put_text("255");
      end else begin
        ndig = $urandom_range(1, wide ? 7 : 5);
        repeat (ndig) body.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
      end
    end
    mode = $urandom_range(0, 19);
    case (mode)
      0: body.insert($urandom_range(0, body.size()), 8'($urandom_range(0, 255)));
      1: body.delete($urandom_range(0, body.size() - 1));
      2: begin
        body.push_back(CHAR_COMMA);
        if ($urandom_range(0, 1) == 1) body.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
      end
      3: body[$urandom_range(0, 2)] = 8'($urandom_range(8'h41, 8'h5A));
      4: begin
        target = $urandom_range(60, 70);
        while (body.size() < target) body.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
      end
      5: body.insert(4, CHAR_COMMA);
      6: begin
        last = '0;
        while (body.size() > 4 && last != CHAR_COMMA) last = body.pop_back();
      end
      default: ;
    endcase
    sum = body_xor();
    lower = $urandom_range(0, 1);
    tail_mode = $urandom_range(0, 15);
    if (tail_mode == 0) sum ^= 8'h01 << $urandom_range(0, 7);
    if ($urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 4)) frame.push_back(8'($urandom_range(0, 255)));
    end
    seal_body(sum, lower);
    if (tail_mode == 1) frame[frame.size() - 2] = 8'($urandom_range(0, 255));
    if (tail_mode == 2) frame[frame.size() - 1] = 8'($urandom_range(0, 255));
    if (tail_mode == 3) frame.push_back(8'($urandom_range(0, 255)));
    else if (tail_mode != 4) frame.push_back(CHAR_NEWLINE);
  endtask

  initial begin
    int sentences;
    sb = new();
    rst          = 1'b1;
    rx_valid     = 1'b0;
    rx_byte      = '0;
    res_ready    = 1'b0;
    bytes_sent   = 0;
    send_gap_max = 12;
    take_gap_max = 12;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Bytes outside a sentence, a coordinate sentence with a wrapping column,
    // and an empty payload that fails at its newline.
    frame.push_back(8'h00);
    frame.push_back(8'hFF);
    send_frame();
    body.delete();
    put_text("COO,9,256");
    seal_body(body_xor(), 1'b0);
    frame.push_back(CHAR_NEWLINE);
    send_frame();
    body.delete();
    seal_body(8'h00, 1'b0);
    frame.push_back(CHAR_NEWLINE);
    send_frame();

    sentences = 0;
    while (bytes_sent < ITEM_TARGET) begin
      if (sentences % 8 == 0) begin
        send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
        take_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
      end
      random_sentence();
      send_frame();
      sentences++;
      if (sentences % 50 == 0) drain();
    end

    drain();
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb_nmea_style_sentence_decoder: clean");
    end else begin
      $display("tb_nmea_style_sentence_decoder: errors");
    end
    $finish;
  end

  initial begin
    int      gap;
    result_t got;
    wait (rst === 1'b0);
    forever begin
      gap = $urandom_range(0, take_gap_max);
      @(negedge clk);
      if (gap > 0) begin
        res_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      res_ready <= 1'b1;
      do @(posedge clk); while (res_valid !== 1'b1);
      got.parse_status = parse_status;
      got.row_value    = row_value;
      got.col_value    = col_value;
      got.hit_value    = hit_value;
      got.first_word   = first_word;
      got.second_word  = second_word;
      sb.check_result(got);
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (rx_valid && rx_ready) || (res_valid && res_ready)) quiet = 0;
      else quiet++;
    end
    $display("tb_nmea_style_sentence_decoder: errors");
    $finish;
  end

endmodule

/* filelist.f */
hdl/nssd_pkg.sv
hdl/nssd_parser.sv
hdl/nssd_out_reg.sv
hdl/nmea_style_sentence_decoder.sv
verif/tb_nmea_style_sentence_decoder.sv
